// ===== rtl/rse_pkg.sv =====
// Shared types and codes for the RPN stack evaluator.
`default_nettype none

package rse_pkg;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;
   localparam int WORD_W     = 32;
   localparam int VALUE_W    = 31;

   localparam logic [2:0] OPC_PUSH   = 3'd0;
   localparam logic [2:0] OPC_ADD    = 3'd1;
   localparam logic [2:0] OPC_SUB    = 3'd2;
   localparam logic [2:0] OPC_MUL    = 3'd3;
   localparam logic [2:0] OPC_DIV    = 3'd4;
   localparam logic [2:0] OPC_FINISH = 3'd5;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_FEW          = 3'd1;
   localparam logic [2:0] ST_FULL         = 3'd2;
   localparam logic [2:0] ST_DIVZERO      = 3'd3;
   localparam logic [2:0] ST_BADOP        = 3'd4;
   localparam logic [2:0] ST_FINISH_DEPTH = 3'd5;

   typedef enum logic [2:0] {
      KIND_PUSH,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_FINISH,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DIV,
      BK_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/rse_front.sv =====
// Front end: accepts request items, decodes the opcode and queues them.
`default_nettype none

module rse_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [rse_pkg::REQ_DATA_W-1:0]    req_tdata,   // [30:0] operand_value, [31] zero
   input  wire  [rse_pkg::REQ_USER_W-1:0]    req_tuser,   // [2:0] opcode
   output logic                              item_valid,
   output rse_pkg::item_type                 item,
   input  wire                               item_pop
);
   import rse_pkg::*;

   item_type   queue_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push, pop;
   item_type   decoded;

   always_comb begin
      decoded.value = req_tdata[VALUE_W-1:0];
      unique case (req_tuser)
         OPC_PUSH:   decoded.kind = KIND_PUSH;
         OPC_ADD:    decoded.kind = KIND_ADD;
         OPC_SUB:    decoded.kind = KIND_SUB;
         OPC_MUL:    decoded.kind = KIND_MUL;
         OPC_DIV:    decoded.kind = KIND_DIV;
         OPC_FINISH: decoded.kind = KIND_FINISH;
         default:    decoded.kind = KIND_BAD;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rse_divider.sv =====
// Signed 32-bit divider, truncating, one quotient bit per cycle.
`default_nettype none

module rse_divider (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [rse_pkg::WORD_W-1:0]     dividend,
   input  wire  [rse_pkg::WORD_W-1:0]     divisor,
   output logic                           done,
   output logic [rse_pkg::WORD_W-1:0]     quotient
);
   import rse_pkg::*;

   localparam int STEP_W = $clog2(WORD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dvd_ff, dvd_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [WORD_W:0]   rem_sh, diff;
   logic              q_bit;

   function automatic logic [WORD_W-1:0] magnitude(logic [WORD_W-1:0] v);
      return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
   endfunction

   assign rem_sh = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign q_bit  = !diff[WORD_W];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         rem_in    = '0;
         dvd_in    = magnitude(dividend);
         dvs_in    = magnitude(divisor);
         neg_in    = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (active_ff) begin
         rem_in  = q_bit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
         dvd_in  = {dvd_ff[WORD_W-2:0], q_bit};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   // most negative / -1 wraps back to most negative here
   assign quotient = neg_ff ? (WORD_W'(0) - dvd_ff) : dvd_ff;

endmodule

`default_nettype wire

// ===== rtl/rse_back.sv =====
// Back end: stack memory, arithmetic sequencer and response register.
`default_nettype none

module rse_back #(
   parameter int STACK_DEPTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               item_valid,
   input  rse_pkg::item_type                 item,
   output logic                              item_pop,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [rse_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [rse_pkg::RSP_USER_W-1:0]    rsp_tuser
);
   import rse_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

   // top of stack lives in top_ff; the memory holds the entries below it
   logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [WORD_W-1:0] top_ff, top_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_final_ff, rsp_final_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CW-1:0]     cnt_m1, cnt_m2;
   logic [WORD_W-1:0] shown_top;
   logic              out_free;
   logic              div_start, div_done;
   logic [WORD_W-1:0] div_quot;

   function automatic logic [RSP_DATA_W-1:0] pack_rsp(logic [2:0] st, logic [CW-1:0] cnt,
                                                      logic [WORD_W-1:0] tv);
      logic [31:0] cnt_wide;
      cnt_wide = 32'(cnt);
      return {cnt_wide[4:0], tv, st};
   endfunction

   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = count_ff - CW'(2);
   assign wr_addr   = cnt_m1[AW-1:0];
   assign rd_addr   = cnt_m2[AW-1:0];
   assign shown_top = (count_ff == '0) ? '0 : top_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   rse_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_final_in = rsp_final_ff;
      item_pop     = 1'b0;
      wr_en        = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (item_valid && out_free) begin
               item_pop     = 1'b1;
               kind_in      = item.kind;
               rsp_valid_in = 1'b1;
               rsp_final_in = 1'b0;
               unique case (item.kind)
                  KIND_PUSH: begin
                     if (count_ff == FULL_CNT) begin
                        rsp_data_in = pack_rsp(ST_FULL, count_ff, shown_top);
                     end else begin
                        wr_en       = (count_ff != '0);
                        top_in      = {1'b0, item.value};
                        count_in    = CW'(count_ff + CW'(1));
                        rsp_data_in = pack_rsp(ST_OK, count_in, top_in);
                     end
                  end
                  KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                     if (count_ff < CW'(2)) begin
                        rsp_data_in = pack_rsp(ST_FEW, count_ff, shown_top);
                     end else if (item.kind == KIND_DIV && top_ff == '0) begin
                        rsp_data_in = pack_rsp(ST_DIVZERO, count_ff, shown_top);
                     end else begin
                        // second operand is read from memory this cycle
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        state_in     = BK_EXEC;
                     end
                  end
                  KIND_FINISH: begin
                     rsp_final_in = 1'b1;
                     if (count_ff == CW'(1)) begin
                        count_in    = '0;
                        rsp_data_in = pack_rsp(ST_OK, '0, top_ff);
                     end else begin
                        rsp_data_in = pack_rsp(ST_FINISH_DEPTH, count_ff, shown_top);
                     end
                  end
                  default: begin
                     rsp_data_in = pack_rsp(ST_BADOP, count_ff, shown_top);
                  end
               endcase
            end
         end
         BK_EXEC: begin
            unique case (kind_ff)
               KIND_ADD: begin
                  top_in   = rd_data_ff + top_ff;
                  count_in = cnt_m1;
                  state_in = BK_RESP;
               end
               KIND_SUB: begin
                  top_in   = rd_data_ff - top_ff;
                  count_in = cnt_m1;
                  state_in = BK_RESP;
               end
               KIND_MUL: begin
                  top_in   = rd_data_ff * top_ff;
                  count_in = cnt_m1;
                  state_in = BK_RESP;
               end
               KIND_DIV: begin
                  div_start = 1'b1;
                  state_in  = BK_DIV;
               end
               default: begin
                  state_in = BK_IDLE;
               end
            endcase
         end
         BK_DIV: begin
            if (div_done) begin
               top_in   = div_quot;
               count_in = cnt_m1;
               state_in = BK_RESP;
            end
         end
         BK_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_final_in = 1'b0;
               rsp_data_in  = pack_rsp(ST_OK, count_ff, top_ff);
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      top_ff       <= top_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_final_ff;

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_evaluator.sv =====
// RPN stack evaluator: request queue front end and stack engine back end.
//
// Request channel req_*: one item per handshake, opcode in req_tuser and the
// push value in req_tdata. A two-entry queue takes items while the engine
// works, so req_tready drops only when the queue is full.
// Result channel rsp_*: exactly one item per request, in request order:
// status, top of stack and depth in rsp_tdata, the finish flag in rsp_tuser.
// Push, finish and every failing item are answered straight from the idle
// state; add, subtract and multiply take one stack memory read, then the
// ALU, then the result register; divide runs through the one-bit-per-cycle
// divider (32 steps plus issue, start, capture and result).
// Throughput: one item per cycle for push, finish and failures while the
// output is free; arithmetic items hold off the next one until answered.
// Reset empties the queue and the stack; no clearing pass is needed.
// When rsp_tready is low the result holds in its output register; the
// engine stops before the next result and the queue keeps filling until
// req_tready drops.
`default_nettype none

module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [rse_pkg::REQ_DATA_W-1:0]    req_tdata,   // [30:0] operand_value, [31] zero
   input  wire  [rse_pkg::REQ_USER_W-1:0]    req_tuser,   // [2:0] opcode
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [rse_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [2:0] status, [34:3] top_value,
                                                          // [39:35] stack_depth
   output logic [rse_pkg::RSP_USER_W-1:0]    rsp_tuser    // [0] is_final
);
   import rse_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_pop;

   rse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   rse_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/rse_checker.sv =====
// Port-level checks for the RPN stack evaluator, bound to the top level.
`default_nettype none

module rse_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [rse_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire [rse_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import rse_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && rsp_tdata[2:0] == ST_OK |-> rsp_tdata[39:35] == 5'd0)
      else $error("successful finish left entries");

   a_final_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[2:0] == ST_OK ||
                                     rsp_tdata[2:0] == ST_FINISH_DEPTH)
      else $error("finish item with wrong status");

   a_divzero_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_DIVZERO |-> rsp_tdata[34:3] == 32'd0 &&
                                                     !rsp_tuser[0])
      else $error("divide by zero with nonzero divisor on top");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
